[rtl/core/ios_pkg.sv]
package ios_pkg;

  localparam int TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    MODE_ACTIVE  = 2'd0,
    MODE_STANDBY = 2'd1,
    MODE_DEEP    = 2'd2
  } mode_t;

  localparam logic [2:0] REG_STANDBY_TO  = 3'd0;
  localparam logic [2:0] REG_DEEP_TO     = 3'd1;
  localparam logic [2:0] REG_INTERVAL    = 3'd2;
  localparam logic [2:0] REG_CONFIRM     = 3'd3;
  localparam logic [2:0] REG_HANG_Y_MIN  = 3'd4;
  localparam logic [2:0] REG_HANG_Z_MAX  = 3'd5;
  localparam logic [2:0] REG_INHIBIT     = 3'd6;

  localparam logic [31:0] STANDBY_TO_RST = 32'd10000;
  localparam logic [31:0] DEEP_TO_RST    = 32'd30000;
  localparam logic [15:0] INTERVAL_RST   = 16'd100;
  localparam logic [3:0]  CONFIRM_RST    = 4'd8;
  localparam logic [15:0] HANG_Y_MIN_RST = 16'd2867;  // 0.70 g
  localparam logic [14:0] HANG_Z_MAX_RST = 15'd1843;  // 0.45 g

  typedef struct packed {
    logic [31:0]        standby_timeout_ms;
    logic [31:0]        deep_timeout_ms;
    logic [15:0]        sample_interval_ms;
    logic [3:0]         confirm_samples;
    logic signed [15:0] hang_y_min;
    logic [14:0]        hang_z_abs_max;
    logic               inhibit;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               touch_active;
    logic               button_pressed;
    logic               external_activity;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } item_t;

  typedef struct packed {
    mode_t      power_mode;
    logic       standby_entered;
    logic       standby_exited;
    logic       deep_sleep_request;
    logic       low_power;
    logic [3:0] hang_count;
  } res_t;

  // state that does not depend on the time width
  typedef struct packed {
    mode_t      mode;
    logic       started;
    logic [3:0] hang_counter;
  } ctl_t;

endpackage

[rtl/core/ios_cfg.sv]
module ios_cfg
  import ios_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_STANDBY_TO: cfg_nxt.standby_timeout_ms    = cfg_data;
        REG_DEEP_TO:    cfg_nxt.deep_timeout_ms       = cfg_data;
        REG_INTERVAL:   cfg_nxt.sample_interval_ms    = cfg_data[15:0];
        REG_CONFIRM:    cfg_nxt.confirm_samples       = cfg_data[3:0];
        REG_HANG_Y_MIN: cfg_nxt.hang_y_min            = cfg_data[15:0];
        REG_HANG_Z_MAX: cfg_nxt.hang_z_abs_max        = cfg_data[14:0];
        REG_INHIBIT:    cfg_nxt.inhibit               = cfg_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.standby_timeout_ms    <= STANDBY_TO_RST;
      cfg_r.deep_timeout_ms       <= DEEP_TO_RST;
      cfg_r.sample_interval_ms    <= INTERVAL_RST;
      cfg_r.confirm_samples       <= CONFIRM_RST;
      cfg_r.hang_y_min            <= HANG_Y_MIN_RST;
      cfg_r.hang_z_abs_max        <= HANG_Z_MAX_RST;
      cfg_r.inhibit               <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/ios_step.sv]
module ios_step
  import ios_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  cfg_t                 cfg,
  input  item_t                item,
  input  ctl_t                 ctl,
  input  logic [TIME_BITS-1:0] act_stamp,
  input  logic [TIME_BITS-1:0] smp_stamp,
  output ctl_t                 ctl_nxt,
  output logic [TIME_BITS-1:0] act_stamp_nxt,
  output logic [TIME_BITS-1:0] smp_stamp_nxt,
  output res_t                 res
);

  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] act_eff;
  logic [3:0]           hang_eff;
  logic [TIME_BITS-1:0] idle;
  logic [TIME_BITS-1:0] since_smp;
  logic                 due;
  logic signed [16:0]   az_ext;
  logic [16:0]          zabs;
  logic                 hanging;
  logic [3:0]           hang_inc;
  logic                 full;
  logic                 past_sb;
  logic                 past_ds;
  logic                 activity;
  logic                 entered;
  logic                 exited;
  logic                 deep;

  assign now      = TIME_BITS'(item.now_ms);
  assign act_eff  = ctl.started ? act_stamp : now;
  assign hang_eff = ctl.started ? ctl.hang_counter : 4'd0;
  assign activity = item.touch_active | item.button_pressed | item.external_activity;

  assign idle      = now - act_eff;
  assign since_smp = now - smp_stamp;
  assign due       = (smp_stamp == '0) ||
                     (CW'(since_smp) >= CW'(cfg.sample_interval_ms));

  assign az_ext  = 17'(item.accel_z);
  assign zabs    = item.accel_z[15] ? 17'(-az_ext) : 17'(az_ext);
  assign hanging = (item.accel_y >= cfg.hang_y_min) &&
                   (zabs <= {2'b00, cfg.hang_z_abs_max});

  assign hang_inc = (hang_eff < cfg.confirm_samples) ? hang_eff + 4'd1 : hang_eff;
  assign full     = hang_inc >= cfg.confirm_samples;
  assign past_sb  = CW'(idle) >= CW'(cfg.standby_timeout_ms);
  assign past_ds  = CW'(idle) >= CW'(cfg.deep_timeout_ms);

  always_comb begin
    ctl_nxt.mode         = ctl.mode;
    ctl_nxt.started      = 1'b1;
    ctl_nxt.hang_counter = hang_eff;
    act_stamp_nxt        = act_eff;
    smp_stamp_nxt        = smp_stamp;
    entered              = 1'b0;
    exited               = 1'b0;
    deep                 = 1'b0;
    if (cfg.inhibit || (activity && ctl.mode != MODE_DEEP)) begin
      exited               = (ctl.mode == MODE_STANDBY);
      ctl_nxt.mode         = MODE_ACTIVE;
      act_stamp_nxt        = now;
      ctl_nxt.hang_counter = 4'd0;
    end else if (ctl.mode != MODE_DEEP && due) begin
      smp_stamp_nxt = now;
      if (!hanging) begin
        ctl_nxt.hang_counter = 4'd0;
        if (ctl.mode == MODE_ACTIVE) begin
          act_stamp_nxt = now;
        end
      end else begin
        ctl_nxt.hang_counter = hang_inc;
        if (ctl.mode == MODE_ACTIVE && full && past_sb) begin
          ctl_nxt.mode = MODE_STANDBY;
          entered      = 1'b1;
        end
        if (full && past_ds) begin
          ctl_nxt.mode = MODE_DEEP;
          deep         = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.power_mode         = ctl_nxt.mode;
    res.standby_entered    = entered;
    res.standby_exited     = exited;
    res.deep_sleep_request = deep;
    res.low_power          = (ctl_nxt.mode != MODE_ACTIVE);
    res.hang_count         = ctl_nxt.hang_counter;
  end

endmodule

[rtl/core/idle_orientation_power_sequencer.sv]
// Channel  | Direction | Ports
// ---------+-----------+--------------------------------------------------
// in       | input     | in_valid, in_stall, in_now_ms .. in_accel_z
// out      | output    | out_valid, out_stall, out_power_mode .. out_hang_count
// cfg      | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One item per cycle while out_stall is low; an item taken into the input register
// goes through the step logic into the result register once the output can advance.
// State is updated as an item moves from the input register to the result register.
// Synchronous active-low reset restores register defaults and the power state.
// in_stall rises only while both registers hold items and out_stall is high.
module idle_orientation_power_sequencer
  import ios_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_ms,
  input  logic        in_touch_active,
  input  logic        in_button_pressed,
  input  logic        in_external_activity,
  input  logic [15:0] in_accel_y,
  input  logic [15:0] in_accel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_power_mode,
  output logic        out_standby_entered,
  output logic        out_standby_exited,
  output logic        out_deep_sleep_request,
  output logic        out_low_power,
  output logic [3:0]  out_hang_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t                 cfg;
  item_t                item_r;
  logic                 in_valid_r, in_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 res_r, res_nxt;
  ctl_t                 ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0] act_stamp_r, act_stamp_nxt;
  logic [TIME_BITS-1:0] smp_stamp_r, smp_stamp_nxt;
  logic                 adv;
  logic                 take;

  ios_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ios_step #(.TIME_BITS(TIME_BITS)) u_step (
    .cfg           (cfg),
    .item          (item_r),
    .ctl           (ctl_r),
    .act_stamp     (act_stamp_r),
    .smp_stamp     (smp_stamp_r),
    .ctl_nxt       (ctl_nxt),
    .act_stamp_nxt (act_stamp_nxt),
    .smp_stamp_nxt (smp_stamp_nxt),
    .res           (res_nxt)
  );

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (take) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      ctl_r.mode        <= MODE_ACTIVE;
      ctl_r.started     <= 1'b0;
      ctl_r.hang_counter <= 4'd0;
      act_stamp_r       <= '0;
      smp_stamp_r       <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        ctl_r       <= ctl_nxt;
        act_stamp_r <= act_stamp_nxt;
        smp_stamp_r <= smp_stamp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.now_ms            <= in_now_ms;
      item_r.touch_active      <= in_touch_active;
      item_r.button_pressed    <= in_button_pressed;
      item_r.external_activity <= in_external_activity;
      item_r.accel_y           <= in_accel_y;
      item_r.accel_z           <= in_accel_z;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_power_mode         = res_r.power_mode;
  assign out_standby_entered    = res_r.standby_entered;
  assign out_standby_exited     = res_r.standby_exited;
  assign out_deep_sleep_request = res_r.deep_sleep_request;
  assign out_low_power          = res_r.low_power;
  assign out_hang_count         = res_r.hang_count;

endmodule

[rtl/core/ios_checker.sv]
module ios_checker
  import ios_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_power_mode,
  input logic        out_standby_entered,
  input logic        out_standby_exited,
  input logic        out_deep_sleep_request,
  input logic        out_low_power,
  input logic [3:0]  out_hang_count
);

  a_low_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_low_power == (out_power_mode != MODE_ACTIVE)))
    else $error("low_power disagrees with power_mode");

  a_exit_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_standby_exited) |->
      (out_power_mode == MODE_ACTIVE && !out_standby_entered && !out_deep_sleep_request))
    else $error("standby exit without return to active");

  a_deep_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_deep_sleep_request) |-> (out_power_mode == MODE_DEEP))
    else $error("deep sleep request without deep mode");

  a_enter_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_standby_entered && !out_deep_sleep_request) |->
      (out_power_mode == MODE_STANDBY))
    else $error("standby entry without standby mode");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_power_mode) && $stable(out_hang_count)))
    else $error("stalled item changed");

endmodule

bind idle_orientation_power_sequencer ios_checker u_ios_checker (.*);

[verif/idle_orientation_power_sequencer_test.sv]
`timescale 1ns / 1ps

module idle_orientation_power_sequencer_test;
  import ios_pkg::*;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;

  // write to an index with no register behind it
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam logic [2:0] ACT_NONE   = 3'b000;
  localparam logic [2:0] ACT_TOUCH  = 3'b100;
  localparam logic [2:0] ACT_BUTTON = 3'b010;
  localparam logic [2:0] ACT_EXT    = 3'b001;
  localparam logic [2:0] ACT_ALL    = 3'b111;

  localparam res_t RES_CLEAR     = '{MODE_ACTIVE, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0};
  localparam res_t RES_BOTH_TO   = '{MODE_DEEP, 1'b1, 1'b0, 1'b1, 1'b1, CONFIRM_RST};
  localparam res_t RES_DEEP_HELD = '{MODE_DEEP, 1'b0, 1'b0, 1'b0, 1'b1, CONFIRM_RST};

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_now_ms;
  logic        in_touch_active;
  logic        in_button_pressed;
  logic        in_external_activity;
  logic [15:0] in_accel_y;
  logic [15:0] in_accel_z;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_power_mode;
  logic        out_standby_entered;
  logic        out_standby_exited;
  logic        out_deep_sleep_request;
  logic        out_low_power;
  logic [3:0]  out_hang_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // shadow of the block's registers and power state
  cfg_t        regs;
  mode_t       pm_mode;
  logic        pm_started;
  logic [31:0] last_activity_ms;
  logic [31:0] last_sample_ms;
  logic [3:0]  hang_run;

  res_t        due_power[$];
  stim_row_t   script[$];
  logic [31:0] clock_ms;

  bit quiet;
  bit hold_req;
  int err_cnt;
  int stuck_cycles;
  int n_items, n_results, n_entered, n_exited, n_deep, n_writes, n_settings;

  always #2 clk = ~clk;

  idle_orientation_power_sequencer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_now_ms             (in_now_ms),
    .in_touch_active       (in_touch_active),
    .in_button_pressed     (in_button_pressed),
    .in_external_activity  (in_external_activity),
    .in_accel_y            (in_accel_y),
    .in_accel_z            (in_accel_z),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_power_mode        (out_power_mode),
    .out_standby_entered   (out_standby_entered),
    .out_standby_exited    (out_standby_exited),
    .out_deep_sleep_request(out_deep_sleep_request),
    .out_low_power         (out_low_power),
    .out_hang_count        (out_hang_count),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  function automatic res_t advance_sequencer(item_t it);
    res_t        r;
    logic        busy, hanging, full;
    logic        entered, exited, deep;
    logic [31:0] idle_ms, since_ms;
    int          zmag;
    entered = 1'b0;
    exited  = 1'b0;
    deep    = 1'b0;
    busy = it.touch_active | it.button_pressed | it.external_activity;
    if (!pm_started) begin
      pm_started = 1'b1;
      last_activity_ms = it.now_ms;
      hang_run = '0;
    end
    if (regs.inhibit) begin
      exited = (pm_mode == MODE_STANDBY);
      pm_mode = MODE_ACTIVE;
      last_activity_ms = it.now_ms;
      hang_run = '0;
    end else if (pm_mode == MODE_DEEP) begin
      // latched: only inhibit or reset gets out
    end else if (busy) begin
      exited = (pm_mode == MODE_STANDBY);
      pm_mode = MODE_ACTIVE;
      last_activity_ms = it.now_ms;
      hang_run = '0;
    end else begin
      idle_ms  = it.now_ms - last_activity_ms;
      since_ms = it.now_ms - last_sample_ms;
      // a stamp of zero means never sampled, so a sample at time 0 stays due
      if (last_sample_ms == 32'd0 || since_ms >= {16'd0, regs.sample_interval_ms}) begin
        last_sample_ms = it.now_ms;
        zmag = int'($signed(it.accel_z));
        if (zmag < 0) zmag = -zmag;
        hanging = ($signed(it.accel_y) >= $signed(regs.hang_y_min)) &&
                  (zmag <= int'(regs.hang_z_abs_max));
        if (!hanging) begin
          hang_run = '0;
          if (pm_mode == MODE_ACTIVE) last_activity_ms = it.now_ms;
        end else begin
          if (hang_run < regs.confirm_samples) hang_run = hang_run + 4'd1;
          full = (hang_run >= regs.confirm_samples);
          if (pm_mode == MODE_ACTIVE && full && idle_ms >= regs.standby_timeout_ms) begin
            pm_mode = MODE_STANDBY;
            entered = 1'b1;
          end
          if (full && idle_ms >= regs.deep_timeout_ms) begin
            pm_mode = MODE_DEEP;
            deep = 1'b1;
          end
        end
      end
    end
    r.power_mode         = pm_mode;
    r.standby_entered    = entered;
    r.standby_exited     = exited;
    r.deep_sleep_request = deep;
    r.low_power          = (pm_mode != MODE_ACTIVE);
    r.hang_count         = hang_run;
    return r;
  endfunction

  function automatic void add_row(logic [31:0] now, logic [2:0] act, int y, int z,
                                  bit typed, res_t want);
    stim_row_t r;
    r.it.now_ms = now;
    {r.it.touch_active, r.it.button_pressed, r.it.external_activity} = act;
    r.it.accel_y = 16'(y);
    r.it.accel_z = 16'(z);
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endfunction

  // mostly a running clock with hanging orientation, some activity and noise
  function automatic item_t rand_item();
    item_t       it;
    int          pick, ymin, zmax;
    logic [31:0] span, step;
    pick = $urandom_range(0, 99);
    ymin = int'($signed(regs.hang_y_min));
    zmax = int'(regs.hang_z_abs_max);
    if (pick < 6) begin
      it.now_ms            = $urandom;
      it.touch_active      = 1'($urandom);
      it.button_pressed    = 1'($urandom);
      it.external_activity = 1'($urandom);
      it.accel_y           = 16'($urandom);
      it.accel_z           = 16'($urandom);
      return it;
    end
    if (pick < 9) begin
      clock_ms = 32'd0;
    end else if (pick < 13) begin
      clock_ms = $urandom;
    end else begin
      span = (regs.deep_timeout_ms > 32'd40000) ? 32'd40000 : regs.deep_timeout_ms;
      if (pick < 75) step = $urandom_range(0, 2 * regs.sample_interval_ms + 2);
      else step = $urandom_range(0, span / 2 + 1);
      clock_ms = clock_ms + step;
    end
    it.now_ms = clock_ms;
    {it.touch_active, it.button_pressed, it.external_activity} =
        ($urandom_range(0, 99) < 8) ? 3'($urandom_range(1, 7)) : ACT_NONE;
    if ($urandom_range(0, 99) < 80) begin
      it.accel_y = 16'($urandom_range(ymin + 32768, 65535) - 32768);
      it.accel_z = 16'(int'($urandom_range(0, 2 * zmax)) - zmax);
    end else begin
      it.accel_y = 16'($urandom);
      it.accel_z = 16'($urandom);
    end
    return it;
  endfunction

  // valid stays up after acceptance; the next call either keeps it or drops it
  task automatic push_item(item_t it, bit typed, res_t want);
    res_t predicted;
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_now_ms            <= it.now_ms;
    in_touch_active      <= it.touch_active;
    in_button_pressed    <= it.button_pressed;
    in_external_activity <= it.external_activity;
    in_accel_y           <= it.accel_y;
    in_accel_z           <= it.accel_z;
    do @(posedge clk); while (in_stall);
    predicted = advance_sequencer(it);
    due_power.push_back(typed ? want : predicted);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_power.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STANDBY_TO: regs.standby_timeout_ms    = val;
      REG_DEEP_TO:    regs.deep_timeout_ms       = val;
      REG_INTERVAL:   regs.sample_interval_ms    = val[15:0];
      REG_CONFIRM:    regs.confirm_samples       = val[3:0];
      REG_HANG_Y_MIN: regs.hang_y_min            = val[15:0];
      REG_HANG_Z_MAX: regs.hang_z_abs_max        = val[14:0];
      REG_INHIBIT:    regs.inhibit               = val[0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  task automatic run_phase(cfg_t c, int n, bit quiet_run, bit hold_run);
    logic [31:0] junk;
    junk = $urandom;
    drain();
    if (!c.inhibit) begin
      // clear a latched deep sleep left by the previous setting
      write_reg(REG_INHIBIT, 32'd1);
      push_item(rand_item(), 1'b0, RES_CLEAR);
      drain();
    end
    // upper bits carry junk that the block must mask off
    write_reg(REG_STANDBY_TO, c.standby_timeout_ms);
    write_reg(REG_DEEP_TO, c.deep_timeout_ms);
    write_reg(REG_INTERVAL, {junk[15:0], c.sample_interval_ms});
    write_reg(REG_CONFIRM, {junk[27:0], c.confirm_samples});
    write_reg(REG_HANG_Y_MIN, {junk[15:0], c.hang_y_min});
    write_reg(REG_HANG_Z_MAX, {junk[16:0], c.hang_z_abs_max});
    write_reg(REG_UNUSED, junk);
    write_reg(REG_INHIBIT, {junk[30:0], c.inhibit});
    n_settings++;
    quiet = quiet_run;
    hold_req = hold_run;
    repeat (n) push_item(rand_item(), 1'b0, RES_CLEAR);
    quiet = 1'b0;
  endtask

  // receiver
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 27);
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      n_entered += int'(out_standby_entered);
      n_exited  += int'(out_standby_exited);
      n_deep    += int'(out_deep_sleep_request);
      if (due_power.size() == 0) begin
        err_cnt++;
        $display("%0t ns: result with nothing expected, mode %0d hang %0d",
                 $time, out_power_mode, out_hang_count);
      end else begin
        want = due_power.pop_front();
        check_field("power_mode", want.power_mode, out_power_mode);
        check_field("standby_entered", want.standby_entered, out_standby_entered);
        check_field("standby_exited", want.standby_exited, out_standby_exited);
        check_field("deep_sleep_request", want.deep_sleep_request, out_deep_sleep_request);
        check_field("low_power", want.low_power, out_low_power);
        check_field("hang_count", want.hang_count, out_hang_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_now_ms            = '0;
    in_touch_active      = 1'b0;
    in_button_pressed    = 1'b0;
    in_external_activity = 1'b0;
    in_accel_y           = '0;
    in_accel_z           = '0;
    cfg_valid            = 1'b0;
    cfg_index            = REG_STANDBY_TO;
    cfg_data             = '0;
    quiet                = 1'b0;
    hold_req             = 1'b0;
    regs = '{STANDBY_TO_RST, DEEP_TO_RST, INTERVAL_RST, CONFIRM_RST,
             HANG_Y_MIN_RST, HANG_Z_MAX_RST, 1'b0};
    pm_mode          = MODE_ACTIVE;
    pm_started       = 1'b0;
    last_activity_ms = '0;
    last_sample_ms   = '0;
    hang_run         = '0;
    clock_ms         = 32'd1000;

    // directed: default settings, walk up to standby, out again, then both timeouts at once
    add_row(32'd1000, ACT_NONE, 0, 0, 1'b1, RES_CLEAR);
    add_row(32'd1050, ACT_NONE, 4096, 0, 1'b1, RES_CLEAR);      // sample not yet due
    for (int k = 0; k < 8; k++)
      add_row(32'd1100 + 32'd1500 * k, ACT_NONE, 4096, 0, 1'b0, RES_CLEAR);
    add_row(32'd11650, ACT_BUTTON, 4096, 0, 1'b0, RES_CLEAR);
    add_row(32'd11700, ACT_EXT, 32767, -32768, 1'b0, RES_CLEAR);
    add_row(32'd11750, ACT_TOUCH, -32768, 32767, 1'b0, RES_CLEAR);
    add_row(32'd11850, ACT_NONE, 2866, 0, 1'b0, RES_CLEAR);     // just below Y threshold
    add_row(32'd11950, ACT_NONE, 4096, 1844, 1'b0, RES_CLEAR);  // just past Z limit
    for (int k = 0; k < 7; k++)
      add_row(32'd12050 + 32'd100 * k, ACT_NONE, (k % 3 == 2) ? 32767 : 2867,
              (k % 3 == 0) ? 1843 : ((k % 3 == 1) ? -1843 : 0), 1'b0, RES_CLEAR);
    add_row(32'd60000, ACT_NONE, 4096, 0, 1'b1, RES_BOTH_TO);
    add_row(32'hFFFF_FFFF, ACT_ALL, -32768, -32768, 1'b1, RES_DEEP_HELD);
    add_row(32'd0, ACT_NONE, 32767, 32767, 1'b1, RES_DEEP_HELD);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) push_item(script[i].it, script[i].typed, script[i].want);

    run_phase('{STANDBY_TO_RST, DEEP_TO_RST, INTERVAL_RST, CONFIRM_RST,
                HANG_Y_MIN_RST, HANG_Z_MAX_RST, 1'b1}, 20, 1'b0, 1'b0);
    run_phase('{32'd300, 32'd900, 16'd20, 4'd3, 16'sd2867, 15'd1843, 1'b0}, 75, 1'b0, 1'b1);
    run_phase('{32'd0, 32'd0, 16'd0, 4'd0, 16'h8000, 15'd32767, 1'b0}, 30, 1'b0, 1'b0);
    run_phase('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd15, 16'sd32767, 15'd0, 1'b0},
              40, 1'b0, 1'b0);
    run_phase('{32'd500, 32'd1500, 16'd50, 4'd1, 16'sd0, 15'd4096, 1'b0}, 60, 1'b1, 1'b0);
    run_phase('{32'd2000, 32'd1000, 16'd10, 4'd4, 16'sd1000, 15'd1000, 1'b0}, 60, 1'b0, 1'b0);
    repeat (3) begin
      c.standby_timeout_ms    = $urandom_range(0, 5000);
      c.deep_timeout_ms       = $urandom_range(0, 12000);
      c.sample_interval_ms    = 16'($urandom_range(0, 300));
      c.confirm_samples       = 4'($urandom_range(0, 15));
      c.hang_y_min            = 16'($urandom);
      c.hang_z_abs_max        = 15'($urandom);
      c.inhibit               = 1'b0;
      run_phase(c, 50, 1'b0, 1'b0);
    end
    run_phase('{STANDBY_TO_RST, DEEP_TO_RST, INTERVAL_RST, CONFIRM_RST,
                HANG_Y_MIN_RST, HANG_Z_MAX_RST, 1'b0}, 60, 1'b0, 1'b0);

    drain();
    $display("Sent %0d items under %0d register settings (%0d writes), checked %0d results;",
             n_items, n_settings, n_writes, n_results);
    $display("saw %0d standby entries, %0d standby exits and %0d deep-sleep requests.",
             n_entered, n_exited, n_deep);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
